[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL files of the rotation matrix block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge while aresetn is high.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_CLK_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[hw/rtl/e2rm_pkg.sv]
// Package for the Euler angle to rotation matrix block: widths, sine ROM and arithmetic helpers.
`timescale 1ns / 1ps
`default_nettype none
package e2rm_pkg;

    // Configuration of the datapath.
    localparam int unsigned ANGLE_BITS       = 16;
    localparam int unsigned FRAC_BITS        = 14;
    localparam int unsigned SINE_TABLE_DEPTH = 1024;

    // Fixed field widths on the ports.
    localparam int unsigned FIELD_W   = 16;
    localparam int unsigned OUT_W     = 16;
    localparam int unsigned N_ANGLES  = 3;
    localparam int unsigned N_OUTS    = 9;
    localparam int unsigned S_DATA_W  = ((N_ANGLES * FIELD_W + 7) / 8) * 8;
    localparam int unsigned M_DATA_W  = ((N_OUTS * OUT_W + 7) / 8) * 8;

    // Derived widths.
    localparam int unsigned PHASE_W = ANGLE_BITS - 2;
    localparam int unsigned IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int unsigned ENTRY_W = FRAC_BITS + 1;
    localparam int unsigned TRIG_W  = FRAC_BITS + 2;
    localparam int unsigned PROD_W  = 2 * TRIG_W;
    localparam int unsigned SUM_W   = TRIG_W + 1;
    localparam int unsigned SCALE_W = PHASE_W + IDX_W;

    // Sine and cosine slots, one pair per angle.
    localparam int unsigned N_TRIG  = 6;
    localparam int unsigned TRIG_SY = 0;
    localparam int unsigned TRIG_CY = 1;
    localparam int unsigned TRIG_SP = 2;
    localparam int unsigned TRIG_CP = 3;
    localparam int unsigned TRIG_SR = 4;
    localparam int unsigned TRIG_CR = 5;

    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << PHASE_W;
    localparam logic [IDX_W-1:0]      IDX_MAX      = IDX_W'(SINE_TABLE_DEPTH);
    localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0]  SUM_ONE   = SUM_W'(1) <<< FRAC_BITS;
    localparam logic signed [OUT_W-1:0]  OUT_ONE   = OUT_W'(SUM_ONE);

    // pi/2 in unsigned Q60
    localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
    // table step in Q60, whole part and remainder
    localparam logic [63:0] HALF_PI_STEP_Q = HALF_PI_Q60 / SINE_TABLE_DEPTH;
    localparam logic [63:0] HALF_PI_STEP_R = HALF_PI_Q60 % SINE_TABLE_DEPTH;

    typedef logic [ENTRY_W-1:0] sine_entry_t;
    typedef sine_entry_t sine_rom_t [0:SINE_TABLE_DEPTH];
    typedef logic signed [TRIG_W-1:0] trig_t;

    // ROM address and sign of one lookup
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             neg;
    } trig_addr_t;

    // (a*b) >> 60 on unsigned Q60 values
    function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] wide;
        wide = {64'd0, a} * {64'd0, b};
        return wide[123:60];
    endfunction

    // Quarter-wave sine table from a Taylor series held in Q60, rounded half up.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] rounded;
        for (int k = 0; k <= int'(SINE_TABLE_DEPTH); k++) begin
            x    = HALF_PI_STEP_Q * 64'(k) + (HALF_PI_STEP_R * 64'(k)) / SINE_TABLE_DEPTH;
            x2   = q60_mul(x, x);
            term = x;
            sum  = x;
            for (int n = 1; n <= 12; n++) begin
                term = q60_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            rounded = (sum + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
            rom[k]  = ENTRY_W'(rounded);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // Quadrant fold: ROM index and sign for the sine of a binary angle
    function automatic trig_addr_t trig_addr(logic [ANGLE_BITS-1:0] angle);
        trig_addr_t       res;
        logic [1:0]       quad;
        logic [SCALE_W-1:0] scaled;
        logic [IDX_W-1:0] idx0;
        quad   = angle[ANGLE_BITS-1 -: 2];
        scaled = SCALE_W'(angle[PHASE_W-1:0]) * SCALE_W'(SINE_TABLE_DEPTH);
        idx0   = IDX_W'(scaled >> PHASE_W);
        res.idx = quad[0] ? (IDX_MAX - idx0) : idx0;
        res.neg = quad[1];
        return res;
    endfunction

    // Apply the quadrant sign to a table entry
    function automatic trig_t trig_value(sine_entry_t entry, logic neg);
        trig_t v;
        v = trig_t'({1'b0, entry});
        return neg ? -v : v;
    endfunction

    // Q product, round half up (floor of product plus half)
    function automatic trig_t qmul(trig_t a, trig_t b);
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'(b) + PROD_HALF;
        return TRIG_W'(p >>> FRAC_BITS);
    endfunction

    // Clamp to +-one and keep the low output bits
    function automatic logic [OUT_W-1:0] sat_out(logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        c = v;
        if (c > SUM_ONE) begin
            c = SUM_ONE;
        end
        if (c < -SUM_ONE) begin
            c = -SUM_ONE;
        end
        return OUT_W'(c);
    endfunction

endpackage
`default_nettype wire

[hw/rtl/euler_to_rotation_matrix.sv]
// Top level: pipelined 2-3-1 Euler angle to rotation matrix converter.
`timescale 1ns / 1ps
`default_nettype none
// Takes one word of three 16-bit binary angles (yaw, pitch, roll; 65536 = one turn)
// per cycle and returns the nine Q1.14 entries of the rotation matrix, each clamped
// to +-16384. Throughput is one word per clock while m_tready does not stall the output;
// each word passes through six register stages: angle folding, sine ROM
// read (one dual-read ROM per angle, sine and cosine), sign apply, the two-factor
// products, the three-factor products, and the final sum and clamp into the output
// register. Stages advance on their own, so bubbles are squeezed out and input is
// taken while a result waits on m_tready. No word is taken while aresetn is low.
module euler_to_rotation_matrix (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [15:0] yaw_angle, [31:16] pitch_angle, [47:32] roll_angle
    input  wire logic [e2rm_pkg::S_DATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [15:0] m_r1c1, [31:16] m_r1c2, [47:32] m_r1c3, [63:48] m_r2c1, [79:64] m_r2c2,
    // [95:80] m_r2c3, [111:96] m_r3c1, [127:112] m_r3c2, [143:128] m_r3c3
    output logic [e2rm_pkg::M_DATA_W-1:0]      m_tdata
);

    localparam int unsigned OW = e2rm_pkg::OUT_W;

    // Stage valids and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, m_tvalid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    assign rdy6     = !m_tvalid_reg || m_tready;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1 && aresetn;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg       <= s_tvalid;
            if (rdy2) v2_reg       <= v1_reg;
            if (rdy3) v3_reg       <= v2_reg;
            if (rdy4) v4_reg       <= v3_reg;
            if (rdy5) v5_reg       <= v4_reg;
            if (rdy6) m_tvalid_reg <= v5_reg;
        end
    end

    // Stage 1: fold each angle into ROM index and sign
    logic [e2rm_pkg::ANGLE_BITS-1:0] angle [0:e2rm_pkg::N_ANGLES-1];
    e2rm_pkg::trig_addr_t            addr_next [0:e2rm_pkg::N_TRIG-1];
    e2rm_pkg::trig_addr_t            addr_reg  [0:e2rm_pkg::N_TRIG-1];

    for (genvar i = 0; i < int'(e2rm_pkg::N_ANGLES); i++) begin : g_fold
        assign angle[i] = e2rm_pkg::ANGLE_BITS'(
            s_tdata[i*e2rm_pkg::FIELD_W +: e2rm_pkg::FIELD_W]);
        assign addr_next[2*i]   = e2rm_pkg::trig_addr(angle[i]);
        assign addr_next[2*i+1] = e2rm_pkg::trig_addr(angle[i] + e2rm_pkg::QUARTER_TURN);
    end

    // Stage 2: registered ROM read, sign travels alongside
    e2rm_pkg::sine_entry_t raw_reg [0:e2rm_pkg::N_TRIG-1];
    logic                  neg_reg [0:e2rm_pkg::N_TRIG-1];
    // Stage 3: signed sine and cosine terms
    e2rm_pkg::trig_t       trig_reg [0:e2rm_pkg::N_TRIG-1];

    for (genvar t = 0; t < int'(e2rm_pkg::N_TRIG); t++) begin : g_trig
        always_ff @(posedge aclk) begin
            if (rdy1) begin
                addr_reg[t] <= addr_next[t];
            end
            if (rdy2) begin
                raw_reg[t] <= e2rm_pkg::SINE_ROM[addr_reg[t].idx];
                neg_reg[t] <= addr_reg[t].neg;
            end
            if (rdy3) begin
                trig_reg[t] <= e2rm_pkg::trig_value(raw_reg[t], neg_reg[t]);
            end
        end
    end

    // Stage 4: two-factor products
    e2rm_pkg::trig_t cycp4_reg, crcy4_reg, srsy4_reg, srcy4_reg;
    e2rm_pkg::trig_t crsy4_reg, crcp4_reg, srcp4_reg, sycp4_reg, sp4_reg;

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            cycp4_reg <= e2rm_pkg::qmul(trig_reg[e2rm_pkg::TRIG_CY], trig_reg[e2rm_pkg::TRIG_CP]);
            crcy4_reg <= e2rm_pkg::qmul(trig_reg[e2rm_pkg::TRIG_CR], trig_reg[e2rm_pkg::TRIG_CY]);
            srsy4_reg <= e2rm_pkg::qmul(trig_reg[e2rm_pkg::TRIG_SR], trig_reg[e2rm_pkg::TRIG_SY]);
            srcy4_reg <= e2rm_pkg::qmul(trig_reg[e2rm_pkg::TRIG_SR], trig_reg[e2rm_pkg::TRIG_CY]);
            crsy4_reg <= e2rm_pkg::qmul(trig_reg[e2rm_pkg::TRIG_CR], trig_reg[e2rm_pkg::TRIG_SY]);
            crcp4_reg <= e2rm_pkg::qmul(trig_reg[e2rm_pkg::TRIG_CR], trig_reg[e2rm_pkg::TRIG_CP]);
            srcp4_reg <= e2rm_pkg::qmul(trig_reg[e2rm_pkg::TRIG_SR], trig_reg[e2rm_pkg::TRIG_CP]);
            sycp4_reg <= e2rm_pkg::qmul(trig_reg[e2rm_pkg::TRIG_SY], trig_reg[e2rm_pkg::TRIG_CP]);
            sp4_reg   <= trig_reg[e2rm_pkg::TRIG_SP];
        end
    end

    // Stage 5: three-factor products, other terms carried
    e2rm_pkg::trig_t crcysp5_reg, srcysp5_reg, crsysp5_reg, srsysp5_reg;
    e2rm_pkg::trig_t cycp5_reg, crcy5_reg, srsy5_reg, srcy5_reg;
    e2rm_pkg::trig_t crsy5_reg, crcp5_reg, srcp5_reg, sycp5_reg, sp5_reg;

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            crcysp5_reg <= e2rm_pkg::qmul(crcy4_reg, sp4_reg);
            srcysp5_reg <= e2rm_pkg::qmul(srcy4_reg, sp4_reg);
            crsysp5_reg <= e2rm_pkg::qmul(crsy4_reg, sp4_reg);
            srsysp5_reg <= e2rm_pkg::qmul(srsy4_reg, sp4_reg);
            cycp5_reg   <= cycp4_reg;
            crcy5_reg   <= crcy4_reg;
            srsy5_reg   <= srsy4_reg;
            srcy5_reg   <= srcy4_reg;
            crsy5_reg   <= crsy4_reg;
            crcp5_reg   <= crcp4_reg;
            srcp5_reg   <= srcp4_reg;
            sycp5_reg   <= sycp4_reg;
            sp5_reg     <= sp4_reg;
        end
    end

    // Stage 6: sums, clamp, output word
    logic [OW-1:0]                 r1c1_next, r1c2_next, r1c3_next;
    logic [OW-1:0]                 r2c1_next, r2c2_next, r2c3_next;
    logic [OW-1:0]                 r3c1_next, r3c2_next, r3c3_next;
    logic [e2rm_pkg::M_DATA_W-1:0] m_tdata_next;
    logic [e2rm_pkg::M_DATA_W-1:0] m_tdata_reg;

    always_comb begin
        r1c1_next = e2rm_pkg::sat_out(e2rm_pkg::SUM_W'(cycp5_reg));
        r1c2_next = e2rm_pkg::sat_out(-e2rm_pkg::SUM_W'(crcysp5_reg)
                                      + e2rm_pkg::SUM_W'(srsy5_reg));
        r1c3_next = e2rm_pkg::sat_out(e2rm_pkg::SUM_W'(srcysp5_reg)
                                      + e2rm_pkg::SUM_W'(crsy5_reg));
        r2c1_next = e2rm_pkg::sat_out(e2rm_pkg::SUM_W'(sp5_reg));
        r2c2_next = e2rm_pkg::sat_out(e2rm_pkg::SUM_W'(crcp5_reg));
        r2c3_next = e2rm_pkg::sat_out(-e2rm_pkg::SUM_W'(srcp5_reg));
        r3c1_next = e2rm_pkg::sat_out(-e2rm_pkg::SUM_W'(sycp5_reg));
        r3c2_next = e2rm_pkg::sat_out(e2rm_pkg::SUM_W'(crsysp5_reg)
                                      + e2rm_pkg::SUM_W'(srcy5_reg));
        r3c3_next = e2rm_pkg::sat_out(-e2rm_pkg::SUM_W'(srsysp5_reg)
                                      + e2rm_pkg::SUM_W'(crcy5_reg));
        m_tdata_next = e2rm_pkg::M_DATA_W'({r3c3_next, r3c2_next, r3c1_next,
                                            r2c3_next, r2c2_next, r2c1_next,
                                            r1c3_next, r1c2_next, r1c1_next});
    end

    always_ff @(posedge aclk) begin
        if (rdy6) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tdata = m_tdata_reg;

    // Checks
`include "assert_macros.svh"

    `ASSERT_CLK_RST(a_reset_empties, !aresetn |=> (!m_tvalid_reg && !v1_reg && !v5_reg), "pipeline not empty after reset")
    `ASSERT_CLK(a_accept_enters, (s_tvalid && s_tready) |=> v1_reg, "accepted word did not enter stage 1")
    `ASSERT_CLK(a_idx_range, v1_reg |-> (addr_reg[e2rm_pkg::TRIG_SY].idx <= e2rm_pkg::IDX_MAX && addr_reg[e2rm_pkg::TRIG_CR].idx <= e2rm_pkg::IDX_MAX), "sine ROM index out of range")
    `ASSERT_CLK(a_stall_holds, (v4_reg && !rdy5) |=> (v4_reg && $stable(crcy4_reg) && $stable(sp4_reg)), "stage 4 lost data under stall")
    `ASSERT_CLK(a_out_clamped, m_tvalid_reg |-> ($signed(m_tdata_reg[8*OW +: OW]) <= e2rm_pkg::OUT_ONE && $signed(m_tdata_reg[8*OW +: OW]) >= -e2rm_pkg::OUT_ONE), "entry outside unit range")

endmodule
`default_nettype wire
